// ----- hw/rtl/csr_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// csr_pkg: shared constants and types of the sparse element store
// Sizes, field widths and status codes used by the core and its RAM.
// ---------------------------------------------------------------------------
package csr_pkg;
  localparam int MAX_ROWS    = 256;
  localparam int MAX_ENTRIES = 1024;
  localparam int COL_BITS    = 12;
  localparam int VALUE_BITS  = 64;
  localparam int ROW_W       = $clog2(MAX_ROWS + 1);
  localparam int PTR_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RADDR_W     = $clog2(MAX_ROWS + 1);
  localparam int ENTRY_W     = COL_BITS + VALUE_BITS;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ----- hw/rtl/csr_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// csr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module csr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/csr_sparse_element_store_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// csr_sparse_element_store_core: sparse matrix element store, CSR form
// Row pointers and a column/value entry array, both held in RAM.
// ---------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_mode, in_row_index, in_col_index,
//          |           | in_write_value
//  out     | output    | out_valid, out_ready, out_found, out_read_value, out_status
//
// One beat is handled at a time. A beat reads three row pointers, then scans its
// row, issuing a read and then a compare for each entry through the entry RAM's
// single read port. An insert or delete then moves every later entry one
// place, one per cycle, and walks the later row pointers with a read and a write
// for each pointer. After reset a clearing pass writes zero into all MAX_ROWS+1
// row pointers while in_ready is low. The result waits in an output register;
// the next beat is taken once that result has been delivered.
module csr_sparse_element_store_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [8:0]  in_row_index,
  input  wire logic [11:0] in_col_index,
  input  wire logic [63:0] in_write_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [63:0]      out_read_value,
  output logic [1:0]       out_status
);
  localparam int PW = csr_pkg::PTR_W;
  localparam int AW = csr_pkg::ADDR_W;
  localparam int RW = csr_pkg::RADDR_W;
  localparam int CB = csr_pkg::COL_BITS;
  localparam int VB = csr_pkg::VALUE_BITS;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RLO   = 13'b0000000000100,
    S_RHI   = 13'b0000000001000,
    S_RCNT  = 13'b0000000010000,
    S_SCAN  = 13'b0000000100000,
    S_SCANW = 13'b0000001000000,
    S_DEC   = 13'b0000010000000,
    S_SHD   = 13'b0000100000000,
    S_SHU   = 13'b0001000000000,
    S_PUT   = 13'b0010000000000,
    S_ROWS  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Item registers.
  logic          mode_r;
  logic [RW-1:0] row_r;
  logic [CB-1:0] col_r;
  logic [VB-1:0] val_r;
  logic [RW-1:0] rows_r, rows_nxt;
  logic [PW-1:0] lo_r, hi_r, cnt_r, i_r, pos_r;
  logic [PW-1:0] lo_nxt, hi_nxt, cnt_nxt, i_nxt, pos_nxt;
  logic          found_r, found_nxt, up_r, up_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic          ov_r, ov_nxt;
  logic          fnd_o_r, fnd_o_nxt;
  logic [63:0]   rv_o_r, rv_o_nxt;
  csr_pkg::status_t st_o_r, st_o_nxt;
  logic          ovld_r, ovld_nxt;
  logic          pend_r, pend_nxt;  // a row-pointer read is in flight

  // Row pointer RAM.
  logic          rp_we;
  logic [RW-1:0] rp_wa, rp_ra;
  logic [PW-1:0] rp_wd, rp_rd;
  // Entry RAM.
  logic                      en_we;
  logic [AW-1:0]             en_wa, en_ra;
  logic [csr_pkg::ENTRY_W-1:0] en_wd, en_rd;
  logic [CB-1:0] en_col;
  logic [VB-1:0] en_val;

  csr_ram #(.WIDTH(PW), .DEPTH(csr_pkg::MAX_ROWS + 1)) u_rowptr (
    .clk(clk), .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd)
  );
  csr_ram #(.WIDTH(csr_pkg::ENTRY_W), .DEPTH(csr_pkg::MAX_ENTRIES)) u_entry (
    .clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(en_ra), .rdata(en_rd)
  );
  assign en_col = en_rd[csr_pkg::ENTRY_W-1:VB];
  assign en_val = en_rd[VB-1:0];

  logic bad_idx, is_zero, accept;
  assign bad_idx = (in_row_index == '0) || (32'(in_row_index) > csr_pkg::MAX_ROWS) ||
                   (in_col_index == '0);
  assign is_zero = (val_r == '0) || (val_r == {1'b1, {(VB-1){1'b0}}});
  assign in_ready = (state_r == S_IDLE) && !ovld_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      row_r  <= RW'(in_row_index);
      col_r  <= CB'(in_col_index);
      val_r  <= VB'(in_write_value);
    end
  end

  always_comb begin
    state_nxt = state_r;
    rows_nxt = rows_r; lo_nxt = lo_r; hi_nxt = hi_r; cnt_nxt = cnt_r;
    i_nxt = i_r; pos_nxt = pos_r; found_nxt = found_r; up_nxt = up_r;
    k_nxt = k_r; ov_nxt = ov_r; pend_nxt = 1'b0;
    fnd_o_nxt = fnd_o_r; rv_o_nxt = rv_o_r; st_o_nxt = st_o_r;
    ovld_nxt = ovld_r && !out_ready;
    rp_we = 1'b0; rp_wa = k_r; rp_wd = '0; rp_ra = '0;
    en_we = 1'b0; en_wa = i_r[AW-1:0]; en_wd = {col_r, val_r}; en_ra = i_r[AW-1:0];
    unique case (state_r)
      S_CLR: begin
        rp_we = 1'b1; rp_wa = k_r; rp_wd = '0;
        k_nxt = k_r + 1'b1;
        if (32'(k_r) == csr_pkg::MAX_ROWS) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          fnd_o_nxt = 1'b0; rv_o_nxt = '0; st_o_nxt = csr_pkg::ST_OK;
          found_nxt = 1'b0;
          if (bad_idx) begin
            st_o_nxt = csr_pkg::ST_BAD;
            ovld_nxt = 1'b1;
          end else begin
            state_nxt = S_RLO;
          end
        end
      end
      S_RLO: begin
        // Issue reads: row_start[row-1], then row_start[row], then count.
        rp_ra = row_r - 1'b1; pend_nxt = 1'b1; state_nxt = S_RHI;
      end
      S_RHI: begin
        rp_ra = row_r; lo_nxt = rp_rd; pend_nxt = 1'b1; state_nxt = S_RCNT;
      end
      S_RCNT: begin
        if (pend_r && !up_r) begin
          hi_nxt = rp_rd; rp_ra = rows_r; up_nxt = 1'b1; pend_nxt = 1'b1;
        end else begin
          up_nxt = 1'b0; cnt_nxt = rp_rd;
          if (row_r > rows_r) begin lo_nxt = rp_rd; hi_nxt = rp_rd; end
          i_nxt = (row_r > rows_r) ? rp_rd : lo_r;
          pos_nxt = (row_r > rows_r) ? rp_rd : hi_r;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue a read of entry i, or finish the scan.
        if (i_r < hi_r) begin
          en_ra = i_r[AW-1:0]; state_nxt = S_SCANW;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_SCANW: begin
        if (en_col == col_r) begin
          found_nxt = 1'b1; pos_nxt = i_r; state_nxt = S_DEC;
        end else if (en_col > col_r) begin
          pos_nxt = i_r; state_nxt = S_DEC;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = S_SCAN;
        end
      end
      S_DEC: begin
        fnd_o_nxt = found_r;
        state_nxt = S_DONE;
        if (mode_r) begin
          if (found_r) rv_o_nxt = 64'(en_val);
        end else if (found_r) begin
          if (!is_zero) begin
            en_we = 1'b1; en_wa = pos_r[AW-1:0];
          end else begin
            i_nxt = pos_r; en_ra = AW'(pos_r + 1'b1); state_nxt = S_SHD;
          end
        end else if (!is_zero) begin
          if (32'(cnt_r) >= csr_pkg::MAX_ENTRIES) begin
            st_o_nxt = csr_pkg::ST_FULL;
          end else begin
            i_nxt = cnt_r; state_nxt = S_SHU;
            if (cnt_r != pos_r) en_ra = AW'(cnt_r - 1'b1);
          end
        end
      end
      S_SHD: begin
        // Entry i+1 is on the read port; move it down to i.
        if (i_r + 1'b1 < cnt_r) begin
          en_we = 1'b1; en_wa = i_r[AW-1:0]; en_wd = en_rd;
          i_nxt = i_r + 1'b1; en_ra = AW'(i_r + 2'd2);
        end else begin
          up_nxt = 1'b0; k_nxt = row_r; state_nxt = S_ROWS; pend_nxt = 1'b1;
          rp_ra = row_r;
        end
      end
      S_SHU: begin
        // Entry i-1 is on the read port; move it up to i.
        if (i_r > pos_r) begin
          en_we = 1'b1; en_wa = i_r[AW-1:0]; en_wd = en_rd;
          i_nxt = i_r - 1'b1; en_ra = AW'(i_r - 2'd2);
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        en_we = 1'b1; en_wa = pos_r[AW-1:0];
        up_nxt = 1'b1;
        if (row_r > rows_r) begin
          // New rows start at the old count; the target row gets count+1.
          k_nxt = rows_r + 1'b1; ov_nxt = 1'b1;
        end else begin
          k_nxt = row_r; ov_nxt = 1'b0;
        end
        rp_ra = (row_r > rows_r) ? rows_r + 1'b1 : row_r;
        pend_nxt = 1'b1; state_nxt = S_ROWS;
      end
      S_ROWS: begin
        // Read-modify-write of one row pointer at a time: a read, then the write.
        if (pend_r) begin
          rp_we = 1'b1; rp_wa = k_r;
          if (ov_r && k_r < row_r) rp_wd = cnt_r;
          else rp_wd = up_r ? ((ov_r) ? cnt_r + 1'b1 : rp_rd + 1'b1) : rp_rd - 1'b1;
          if (k_r >= ((ov_r) ? row_r : rows_r)) begin
            if (ov_r) rows_nxt = row_r;
            ov_nxt = 1'b0; up_nxt = 1'b0; state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          rp_ra = k_r; pend_nxt = 1'b1;
        end
      end
      S_DONE: begin
        ovld_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      rows_r  <= '0;
      k_r     <= '0;
      ovld_r  <= 1'b0;
      pend_r  <= 1'b0;
      up_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      k_r     <= k_nxt;
      ovld_r  <= ovld_nxt;
      pend_r  <= pend_nxt;
      up_r    <= up_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt;
    pos_r <= pos_nxt; found_r <= found_nxt;
    fnd_o_r <= fnd_o_nxt; rv_o_r <= rv_o_nxt; st_o_r <= st_o_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_found      = fnd_o_r;
  assign out_read_value = rv_o_r;
  assign out_status     = st_o_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rows_r) <= csr_pkg::MAX_ROWS) else $error("row range overflow");
`endif
endmodule
`default_nettype wire
